[hw/rtl/eop_pkg.sv]
package eop_pkg;

  localparam int CFG_W   = 24;
  localparam int DPP_W   = 24;
  localparam int TW_W    = 20;
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 19;

  localparam int MUL_W   = 36;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIV_NW  = 63;
  localparam int DIV_DW  = 32;
  localparam int ANG_W   = 35;
  localparam int CXY_W   = 34;
  localparam int ATAN_N  = 24;
  localparam int ATAN_IW = 5;

  localparam logic signed [ANG_W-1:0] PI30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI30  = 35'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI30 = 35'sd1686629713;
  localparam logic signed [CXY_W-1:0] CORDIC_K  = 34'sd652032874;
  localparam logic [30:0]             ONE30     = 31'd1073741824;
  localparam logic [31:0]             PI30_U    = 32'd3373259426;
  localparam logic signed [20:0]      PI16      = 21'sd205887;
  localparam logic signed [20:0]      TWO_PI16  = 21'sd411775;

  typedef enum logic [1:0] {
    REQ_LEFT  = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic {
    REG_DPP = 1'b0,
    REG_TW  = 1'b1
  } reg_e;

  function automatic logic [29:0] atan_f(input logic [ATAN_IW-1:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/eop_if.sv]
interface eop_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       phase_a;
  logic       phase_b;

  modport source (output valid, output req_type, output phase_a, output phase_b, input ready);
  modport sink (input valid, input req_type, input phase_a, input phase_b, output ready);
endinterface

interface eop_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

[hw/rtl/eop_mul.sv]
module eop_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [eop_pkg::MUL_W-1:0]    a_i,
  input  logic signed [eop_pkg::MUL_W-1:0]    b_i,
  output logic                                done_o,
  output logic signed [eop_pkg::PROD_W-1:0]  p_o
);

  localparam int W  = eop_pkg::MUL_W;
  localparam int CW = $clog2(W);

  logic                              busy_q;
  logic                              done_q;
  logic [CW-1:0]                     cnt_q;
  logic [W-1:0]                      a_q;
  logic [W-1:0]                      hi_q;
  logic [W-1:0]                      lo_q;
  logic                              neg_q;
  logic signed [eop_pkg::PROD_W-1:0] p_q;
  logic [W-1:0]                      a_mag;
  logic [W-1:0]                      b_mag;
  logic [W:0]                        add_s;
  logic [2*W-1:0]                    prod_u;

  assign a_mag  = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign b_mag  = b_i[W-1] ? W'(-b_i) : W'(b_i);
  assign add_s  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
  assign prod_u = {add_s, lo_q[W-1:1]};

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag;
      lo_q  <= b_mag;
      hi_q  <= '0;
      neg_q <= a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      {hi_q, lo_q} <= prod_u;
      if (cnt_q == CW'(W - 1)) begin
        p_q <= neg_q ? -$signed(prod_u) : $signed(prod_u);
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

[hw/rtl/eop_div.sv]
module eop_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [eop_pkg::DIV_NW-1:0]   num_i,
  input  logic [eop_pkg::DIV_DW-1:0]   den_i,
  output logic                         done_o,
  output logic [eop_pkg::DIV_NW-1:0]   quo_o
);

  localparam int NW = eop_pkg::DIV_NW;
  localparam int DW = eop_pkg::DIV_DW;
  localparam int CW = $clog2(NW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] n_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] q_q;
  logic [DW:0]   trial;
  logic [DW:0]   sub;
  logic          ge;
  logic [NW-1:0] n_next;

  assign trial  = {rem_q, n_q[NW-1]};
  assign sub    = trial - {1'b0, d_q};
  assign ge     = trial >= {1'b0, d_q};
  assign n_next = {n_q[NW-2:0], ge};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= n_next;
      rem_q <= ge ? sub[DW-1:0] : trial[DW-1:0];
      if (cnt_q == CW'(NW - 1)) begin
        q_q <= n_next;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

[hw/rtl/eop_cordic.sv]
module eop_cordic #(
  parameter int STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [eop_pkg::ANG_W-1:0]   ang_i,
  output logic                               done_o,
  output logic signed [eop_pkg::CXY_W-1:0]   cos_o,
  output logic signed [eop_pkg::CXY_W-1:0]   sin_o
);

  localparam int AW = eop_pkg::ANG_W;
  localparam int XW = eop_pkg::CXY_W;
  localparam int CW = $clog2(STEPS);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [XW-1:0] x_q;
  logic signed [XW-1:0] y_q;
  logic signed [AW-1:0] z_q;
  logic                 neg_q;
  logic signed [XW-1:0] c_q;
  logic signed [XW-1:0] s_q;
  logic signed [AW-1:0] z_a;
  logic signed [AW-1:0] z_f;
  logic                 neg_f;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  logic signed [AW-1:0] at;
  logic signed [XW-1:0] x_n;
  logic signed [XW-1:0] y_n;
  logic signed [AW-1:0] z_n;

  // fold into the right half plane
  always_comb begin
    z_a   = ang_i;
    z_f   = '0;
    neg_f = 1'b0;
    if (ang_i > eop_pkg::PI30) begin
      z_a = ang_i - eop_pkg::TWO_PI30;
    end else if (ang_i < -eop_pkg::PI30) begin
      z_a = ang_i + eop_pkg::TWO_PI30;
    end
    z_f = z_a;
    if (z_a > eop_pkg::HALF_PI30) begin
      z_f   = z_a - eop_pkg::PI30;
      neg_f = 1'b1;
    end else if (z_a < -eop_pkg::HALF_PI30) begin
      z_f   = z_a + eop_pkg::PI30;
      neg_f = 1'b1;
    end
  end

  always_comb begin
    sx = x_q >>> cnt_q;
    sy = y_q >>> cnt_q;
    at = $signed({{(AW - 30){1'b0}}, eop_pkg::atan_f(eop_pkg::ATAN_IW'(cnt_q))});
    if (!z_q[AW-1]) begin
      x_n = x_q - sy;
      y_n = y_q + sx;
      z_n = z_q - at;
    end else begin
      x_n = x_q + sy;
      y_n = y_q - sx;
      z_n = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= eop_pkg::CORDIC_K;
      y_q   <= '0;
      z_q   <= z_f;
      neg_q <= neg_f;
    end else if (busy_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (cnt_q == CW'(STEPS - 1)) begin
        c_q <= neg_q ? -x_n : x_n;
        s_q <= neg_q ? -y_n : y_n;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = c_q;
  assign sin_o  = s_q;

endmodule

[hw/rtl/encoder_odometry_pose.sv]
// Differential-drive odometry from two quadrature wheel encoders. Each left or right
// edge request (phase levels after the edge) bumps a saturating signed pulse counter.
// A tick request turns both counts into Q16.16 wheel travel, clears them, updates the
// pose (x, y in Q16.16 metres, heading in Q2.16 radians wrapped to +-pi) about the
// centre of curvature and then offers one result; edges give no result. A tick runs six
// products through one 36-bit shift-add multiplier, two quotients through a
// one-bit-per-cycle divider and two CORDIC runs, forms the wheel sum and loads the
// result; when both wheels travel the same distance it skips both quotients and one
// CORDIC run. The load waits while the previous pose is still unread. A finished pose
// waits in the output register while edge requests are still taken. distance_per_pulse
// (index 0, 2^-32 m per pulse) and track_width (index 1, Q16.16 m, zero acts as one)
// may be written while idle.
module encoder_odometry_pose #(
  parameter int COUNT_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  eop_req_if.sink                      req_i,
  eop_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [eop_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int MW = eop_pkg::MUL_W;
  localparam int PW = eop_pkg::PROD_W;
  localparam int CB = COUNT_BITS;
  localparam logic signed [CB-1:0] CNT_MAX = {1'b0, {(CB - 1){1'b1}}};
  localparam logic signed [CB-1:0] CNT_MIN = {1'b1, {(CB - 1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_ML, S_MR, S_SD, S_DTH, S_CS, S_SINC, S_CH, S_TX, S_TY, S_PX, S_PY, S_OUT
  } state_e;

  state_e                              state_q;
  logic [eop_pkg::DPP_W-1:0]           dpp_q;
  logic [eop_pkg::TW_W-1:0]            tw_q;
  logic signed [CB-1:0]                lcnt_q;
  logic signed [CB-1:0]                rcnt_q;
  logic signed [31:0]                  x_q;
  logic signed [31:0]                  y_q;
  logic signed [18:0]                  head_q;
  logic signed [31:0]                  dl_q;
  logic signed [31:0]                  dr_q;
  logic signed [32:0]                  sum_q;
  logic signed [32:0]                  dth_q;
  logic signed [32:0]                  half_q;
  logic [30:0]                         sinc_q;
  logic                                sneg_q;
  logic signed [eop_pkg::CXY_W-1:0]    s_q;
  logic signed [MW-1:0]                tx_q;
  logic signed [MW-1:0]                ty_q;
  logic                                out_valid_q;
  logic signed [31:0]                  out_x_q;
  logic signed [31:0]                  out_y_q;
  logic signed [18:0]                  out_h_q;

  logic                                mul_start_q;
  logic signed [MW-1:0]                mul_a_q;
  logic signed [MW-1:0]                mul_b_q;
  logic                                mul_done;
  logic signed [PW-1:0]                mul_p;
  logic                                div_start_q;
  logic [eop_pkg::DIV_NW-1:0]          div_n_q;
  logic [eop_pkg::DIV_DW-1:0]          div_d_q;
  logic                                div_done;
  logic [eop_pkg::DIV_NW-1:0]          div_q;
  logic                                cor_start_q;
  logic signed [eop_pkg::ANG_W-1:0]    cor_ang_q;
  logic                                cor_done;
  logic signed [eop_pkg::CXY_W-1:0]    cor_c;
  logic signed [eop_pkg::CXY_W-1:0]    cor_s;

  logic                                req_fire;
  logic                                same;
  logic signed [32:0]                  diff_w;
  logic [32:0]                         diff_mag;
  logic [31:0]                         mag_w;
  logic signed [32:0]                  dth_w;
  logic signed [32:0]                  half_w;
  logic [eop_pkg::DIV_DW-1:0]          tw_nz;
  logic [32:0]                         half_mag;
  logic signed [eop_pkg::ANG_W-1:0]    head_ang;
  logic signed [32:0]                  dth_rnd;
  logic signed [20:0]                  h_sum;
  logic signed [20:0]                  h_wrap;
  logic signed [PW:0]                  x_sum;
  logic signed [PW:0]                  y_sum;

  function automatic logic signed [PW-1:0] rnd_f(input logic signed [PW-1:0] v,
                                                 input int n);
    logic signed [PW-1:0] one;
    one = PW'(1);
    return (v + (one <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [PW:0] v);
    logic signed [31:0] r;
    if (v > (PW + 1)'(2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -(PW + 1)'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [CB-1:0] bump_f(input logic signed [CB-1:0] c,
                                                  input logic up);
    logic signed [CB-1:0] r;
    if (up) begin
      r = (c == CNT_MAX) ? c : c + 1'b1;
    end else begin
      r = (c == CNT_MIN) ? c : c - 1'b1;
    end
    return r;
  endfunction

  assign req_fire = req_i.valid && req_i.ready;
  assign same     = req_i.phase_a == req_i.phase_b;
  assign diff_w   = 33'(dr_q) - 33'(dl_q);
  assign diff_mag = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
  assign tw_nz    = (tw_q == '0) ? eop_pkg::DIV_DW'(1) : eop_pkg::DIV_DW'(tw_q);
  assign mag_w    = (div_q > eop_pkg::DIV_NW'(eop_pkg::PI30_U)) ? eop_pkg::PI30_U
                                                                   : div_q[31:0];
  assign dth_w    = diff_w[32] ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
  assign half_w   = (dth_w + $signed({32'd0, dth_w[32]})) >>> 1;
  assign half_mag = half_q[32] ? 33'(-half_q) : 33'(half_q);
  assign head_ang = ($signed(eop_pkg::ANG_W'(head_q)) <<< 14) + eop_pkg::ANG_W'(half_q);
  assign dth_rnd  = (dth_q + 33'sd8192) >>> 14;
  assign h_sum    = 21'(head_q) + dth_rnd[20:0];
  assign x_sum    = (PW + 1)'(x_q) + (PW + 1)'(rnd_f(mul_p, 31));
  assign y_sum    = (PW + 1)'(y_q) + (PW + 1)'(rnd_f(mul_p, 31));

  always_comb begin
    h_wrap = h_sum;
    if (h_sum > eop_pkg::PI16) begin
      h_wrap = h_sum - eop_pkg::TWO_PI16;
    end else if (h_sum < -eop_pkg::PI16) begin
      h_wrap = h_sum + eop_pkg::TWO_PI16;
    end
  end

  logic [eop_pkg::CXY_W-1:0] cs_mag;
  assign cs_mag = cor_s[eop_pkg::CXY_W-1] ? eop_pkg::CXY_W'(-cor_s) : eop_pkg::CXY_W'(cor_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dpp_q       <= eop_pkg::DPP_W'(409758);
      tw_q        <= eop_pkg::TW_W'(7864);
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      head_q      <= '0;
      dl_q        <= '0;
      dr_q        <= '0;
      sum_q       <= '0;
      dth_q       <= '0;
      half_q      <= '0;
      sinc_q      <= '0;
      sneg_q      <= 1'b0;
      s_q         <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_start_q <= 1'b0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      cor_start_q <= 1'b0;
      cor_ang_q   <= '0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      cor_start_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (eop_pkg::reg_e'(cfg_idx_i))
          eop_pkg::REG_DPP: dpp_q <= cfg_wdata_i[eop_pkg::DPP_W-1:0];
          eop_pkg::REG_TW:  tw_q  <= cfg_wdata_i[eop_pkg::TW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            unique case (eop_pkg::req_e'(req_i.req_type))
              eop_pkg::REQ_LEFT:  lcnt_q <= bump_f(lcnt_q, !same);
              eop_pkg::REQ_RIGHT: rcnt_q <= bump_f(rcnt_q, same);
              eop_pkg::REQ_TICK: begin
                mul_a_q     <= MW'(lcnt_q);
                mul_b_q     <= $signed(MW'(dpp_q));
                mul_start_q <= 1'b1;
                state_q     <= S_ML;
              end
              default: ;
            endcase
          end
        end
        S_ML: begin
          if (mul_done) begin
            dl_q        <= sat32_f((PW + 1)'(rnd_f(mul_p, 16)));
            mul_a_q     <= MW'(rcnt_q);
            mul_b_q     <= $signed(MW'(dpp_q));
            mul_start_q <= 1'b1;
            state_q     <= S_MR;
          end
        end
        S_MR: begin
          if (mul_done) begin
            dr_q    <= sat32_f((PW + 1)'(rnd_f(mul_p, 16)));
            lcnt_q  <= '0;
            rcnt_q  <= '0;
            state_q <= S_SD;
          end
        end
        S_SD: begin
          sum_q <= 33'(dl_q) + 33'(dr_q);
          if (diff_w != '0) begin
            div_n_q     <= {diff_mag[32:0], 30'd0};
            div_d_q     <= tw_nz;
            div_start_q <= 1'b1;
            state_q     <= S_DTH;
          end else begin
            dth_q       <= '0;
            half_q      <= '0;
            sinc_q      <= eop_pkg::ONE30;
            cor_ang_q   <= $signed(eop_pkg::ANG_W'(head_q)) <<< 14;
            cor_start_q <= 1'b1;
            state_q     <= S_CH;
          end
        end
        S_DTH: begin
          if (div_done) begin
            dth_q       <= dth_w;
            half_q      <= half_w;
            cor_ang_q   <= eop_pkg::ANG_W'(half_w);
            cor_start_q <= 1'b1;
            state_q     <= S_CS;
          end
        end
        S_CS: begin
          if (cor_done) begin
            div_n_q     <= eop_pkg::DIV_NW'({cs_mag, 30'd0});
            div_d_q     <= half_mag[31:0];
            div_start_q <= 1'b1;
            sneg_q      <= cor_s[eop_pkg::CXY_W-1] ^ half_q[32];
            state_q     <= S_SINC;
          end
        end
        S_SINC: begin
          if (div_done) begin
            if (sneg_q) begin
              sinc_q <= '0;
            end else if (div_q > eop_pkg::DIV_NW'(eop_pkg::ONE30)) begin
              sinc_q <= eop_pkg::ONE30;
            end else begin
              sinc_q <= div_q[30:0];
            end
            cor_ang_q   <= head_ang;
            cor_start_q <= 1'b1;
            state_q     <= S_CH;
          end
        end
        S_CH: begin
          if (cor_done) begin
            s_q         <= cor_s;
            mul_a_q     <= MW'(sum_q);
            mul_b_q     <= MW'(cor_c);
            mul_start_q <= 1'b1;
            state_q     <= S_TX;
          end
        end
        S_TX: begin
          if (mul_done) begin
            tx_q        <= MW'(rnd_f(mul_p, 30));
            mul_a_q     <= MW'(sum_q);
            mul_b_q     <= MW'(s_q);
            mul_start_q <= 1'b1;
            state_q     <= S_TY;
          end
        end
        S_TY: begin
          if (mul_done) begin
            ty_q        <= MW'(rnd_f(mul_p, 30));
            mul_a_q     <= tx_q;
            mul_b_q     <= $signed(MW'(sinc_q));
            mul_start_q <= 1'b1;
            state_q     <= S_PX;
          end
        end
        S_PX: begin
          if (mul_done) begin
            x_q         <= sat32_f(x_sum);
            mul_a_q     <= ty_q;
            mul_b_q     <= $signed(MW'(sinc_q));
            mul_start_q <= 1'b1;
            state_q     <= S_PY;
          end
        end
        S_PY: begin
          if (mul_done) begin
            y_q     <= sat32_f(y_sum);
            head_q  <= h_wrap[18:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || res_o.ready) begin
            out_x_q     <= x_q;
            out_y_q     <= y_q;
            out_h_q     <= head_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  eop_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  eop_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_n_q),
    .den_i   (div_d_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  eop_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start_q),
    .ang_i   (cor_ang_q),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = out_valid_q;
  assign res_o.pos_x   = out_x_q;
  assign res_o.pos_y   = out_y_q;
  assign res_o.heading = out_h_q;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (21'(head_q) <= eop_pkg::PI16) && (21'(head_q) >= -eop_pkg::PI16))
    else $error("heading out of range");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_start_q, div_start_q, cor_start_q}))
    else $error("two units started together");

  a_tick_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && req_i.req_type == eop_pkg::REQ_TICK) |=> (mul_start_q && state_q == S_ML))
    else $error("tick did not start the update");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || res_o.ready)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not loaded");
`endif

endmodule

[test/eop_tb_if.sv]
interface eop_cfg_if;
  logic                      we;
  logic                      idx;
  logic [eop_pkg::CFG_W-1:0] wdata;

  modport source (output we, output idx, output wdata);
  modport sink (input we, input idx, input wdata);
endinterface

[test/testbench.sv]
module testbench;

  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 600;
  localparam int  HOLD_CYCLES = 3000;
  localparam longint Q30      = 64'sd1073741824;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint TWOPI_Q30 = 64'sd6746518852;
  localparam longint PI_Q16   = 64'sd205887;
  localparam longint TWOPI_Q16 = 64'sd411775;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int  ROT_STEPS   = 16;
  localparam longint CNT_MAX  = 64'sd32767;
  localparam longint CNT_MIN  = -64'sd32768;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [18:0] h;
  } pose_t;

  typedef struct {
    eop_pkg::req_e req;
    bit            a;
    bit            b;
    bit            typed;
    pose_t         pose;
  } stim_row_t;

  logic clk;
  logic rst_n;
  eop_req_if req_bus ();
  eop_res_if res_bus ();
  eop_cfg_if cfg_bus ();

  encoder_odometry_pose uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_bus),
    .res_o       (res_bus),
    .cfg_we_i    (cfg_bus.we),
    .cfg_idx_i   (cfg_bus.idx),
    .cfg_wdata_i (cfg_bus.wdata)
  );

  longint atan_q30 [ROT_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768
  };

  longint pulse_dist, wheel_base;
  longint left_pulses, right_pulses, pose_x, pose_y, pose_h;
  pose_t  pose_q [$];
  int     err_cnt = 0;
  int     cycles = 0;
  int     send_idle_pct, recv_stall_pct;
  bit     hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver, with one long hold when requested
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready = 1'b0;
      end else begin
        res_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    pose_t got, want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.pos_x, res_bus.pos_y, res_bus.heading};
      if (pose_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected pose x=%0d y=%0d h=%0d", got.x, got.y, got.h);
      end else begin
        want = pose_q.pop_front();
        if (got != want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("pose mismatch: exp x=%0d y=%0d h=%0d got x=%0d y=%0d h=%0d",
                     want.x, want.y, want.h, got.x, got.y, got.h);
        end
      end
    end
  end

  function automatic longint rshift_rnd(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp32(longint v);
    return clamp(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint z, x, y, sx, sy;
    bit     neg;
    z = ang;
    x = GAIN_Q30;
    y = 0;
    neg = 1'b0;
    if (z > PI_Q30) z -= TWOPI_Q30;
    else if (z < -PI_Q30) z += TWOPI_Q30;
    if (z > PI_Q30 / 2) begin
      z -= PI_Q30;
      neg = 1'b1;
    end else if (z < -PI_Q30 / 2) begin
      z += PI_Q30;
      neg = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      sx = x >>> i;
      sy = y >>> i;
      if (z >= 0) begin
        x -= sy;
        y += sx;
        z -= atan_q30[i];
      end else begin
        x += sy;
        y -= sx;
        z += atan_q30[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic pose_t advance_pose();
    longint dl, dr, sum, diff, dth, half, sinc, c, s, tx, ty, h;
    longint unsigned mag, tw;
    dth = 0;
    half = 0;
    sinc = Q30;
    dl = clamp32(rshift_rnd(left_pulses * pulse_dist, 16));
    dr = clamp32(rshift_rnd(right_pulses * pulse_dist, 16));
    left_pulses = 0;
    right_pulses = 0;
    sum = dl + dr;
    diff = dr - dl;
    if (diff != 0) begin
      tw = (wheel_base != 0) ? wheel_base : 1;
      mag = longint'(diff < 0 ? -diff : diff);
      mag = mag * 64'd1073741824 / tw;
      if (mag > PI_Q30) mag = PI_Q30;
      dth = diff < 0 ? -longint'(mag) : longint'(mag);
      half = dth / 2;
      rotate(half, c, s);
      sinc = clamp(s * Q30 / half, 0, Q30);
    end
    rotate(pose_h * 16384 + half, c, s);
    tx = rshift_rnd(sum * c, 30);
    ty = rshift_rnd(sum * s, 30);
    pose_x = clamp32(pose_x + rshift_rnd(tx * sinc, 31));
    pose_y = clamp32(pose_y + rshift_rnd(ty * sinc, 31));
    h = pose_h + rshift_rnd(dth, 14);
    if (h > PI_Q16) h -= TWOPI_Q16;
    else if (h < -PI_Q16) h += TWOPI_Q16;
    pose_h = h;
    return '{pose_x[31:0], pose_y[31:0], pose_h[18:0]};
  endfunction

  function automatic void track_request(eop_pkg::req_e r, bit a, bit b);
    case (r)
      eop_pkg::REQ_LEFT:
        left_pulses = clamp(left_pulses + ((a != b) ? 1 : -1), CNT_MIN, CNT_MAX);
      eop_pkg::REQ_RIGHT:
        right_pulses = clamp(right_pulses + ((a == b) ? 1 : -1), CNT_MIN, CNT_MAX);
      eop_pkg::REQ_TICK:  pose_q.push_back(advance_pose());
      default: ;
    endcase
  endfunction

  task automatic send_request(eop_pkg::req_e r, bit a, bit b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid    = 1'b1;
    req_bus.req_type = r;
    req_bus.phase_a  = a;
    req_bus.phase_b  = b;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic issue(eop_pkg::req_e r, bit a, bit b);
    send_request(r, a, b);
    track_request(r, a, b);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_bus.valid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(eop_pkg::reg_e idx, longint unsigned val);
    cfg_bus.we    = 1'b1;
    cfg_bus.idx   = idx;
    cfg_bus.wdata = val[eop_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_bus.we    = 1'b0;
    if (idx == eop_pkg::REG_DPP) pulse_dist = val & 64'hFFFFFF;
    else wheel_base = val & 64'hFFFFF;
  endtask

  task automatic run_random(int n);
    int  sent, len, kind;
    bit  up_l, up_r, a, b, side;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        a = $urandom_range(1);
        b = $urandom_range(1);
        issue(eop_pkg::req_e'($urandom_range(3)), a, b);
        sent++;
      end else begin
        len = $urandom_range(24);
        up_l = $urandom_range(1);
        up_r = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
          side = $urandom_range(1);
          a = $urandom_range(1);
          if ($urandom_range(7) == 0) b = $urandom_range(1);
          else if (side) b = up_r ? a : ~a;
          else b = up_l ? ~a : a;
          issue(side ? eop_pkg::REQ_RIGHT : eop_pkg::REQ_LEFT, a, b);
          sent++;
        end
        issue(eop_pkg::REQ_TICK, $urandom_range(1), $urandom_range(1));
        sent++;
      end
    end
  endtask

  stim_row_t directed [24] = '{
    '{eop_pkg::REQ_TICK,  0, 0, 1, '{32'sd0, 32'sd0, 19'sd0}},
    '{eop_pkg::REQ_LEFT,  0, 0, 0, '0},
    '{eop_pkg::REQ_LEFT,  0, 1, 0, '0},
    '{eop_pkg::REQ_LEFT,  1, 0, 0, '0},
    '{eop_pkg::REQ_LEFT,  1, 1, 0, '0},
    '{eop_pkg::REQ_RIGHT, 0, 0, 0, '0},
    '{eop_pkg::REQ_RIGHT, 0, 1, 0, '0},
    '{eop_pkg::REQ_RIGHT, 1, 0, 0, '0},
    '{eop_pkg::REQ_RIGHT, 1, 1, 0, '0},
    '{eop_pkg::REQ_NONE,  1, 1, 0, '0},
    '{eop_pkg::REQ_TICK,  1, 1, 1, '{32'sd0, 32'sd0, 19'sd0}},
    '{eop_pkg::REQ_LEFT,  1, 0, 0, '0},
    '{eop_pkg::REQ_RIGHT, 1, 1, 0, '0},
    '{eop_pkg::REQ_LEFT,  0, 1, 0, '0},
    '{eop_pkg::REQ_RIGHT, 0, 0, 0, '0},
    '{eop_pkg::REQ_TICK,  0, 1, 0, '0},
    '{eop_pkg::REQ_RIGHT, 1, 1, 0, '0},
    '{eop_pkg::REQ_RIGHT, 0, 0, 0, '0},
    '{eop_pkg::REQ_RIGHT, 1, 1, 0, '0},
    '{eop_pkg::REQ_TICK,  1, 0, 0, '0},
    '{eop_pkg::REQ_LEFT,  1, 0, 0, '0},
    '{eop_pkg::REQ_LEFT,  1, 0, 0, '0},
    '{eop_pkg::REQ_TICK,  0, 0, 0, '0},
    '{eop_pkg::REQ_NONE,  0, 0, 0, '0}
  };

  initial begin
    req_bus.valid    = 1'b0;
    req_bus.req_type = eop_pkg::REQ_NONE;
    req_bus.phase_a  = 1'b0;
    req_bus.phase_b  = 1'b0;
    cfg_bus.we       = 1'b0;
    cfg_bus.idx      = eop_pkg::REG_DPP;
    cfg_bus.wdata    = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pulse_dist = 409758;
    wheel_base = 7864;
    left_pulses = 0;
    right_pulses = 0;
    pose_x = 0;
    pose_y = 0;
    pose_h = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].a, directed[i].b);
      if (directed[i].typed) begin
        void'(advance_pose());
        pose_q.push_back(directed[i].pose);
      end else begin
        track_request(directed[i].req, directed[i].a, directed[i].b);
      end
      @(negedge clk);
    end
    run_random(35);
    wait_idle();

    write_reg(eop_pkg::REG_DPP, 24'hFFFFFF);
    write_reg(eop_pkg::REG_TW, 1);
    send_idle_pct = 83;
    run_random(35);
    wait_idle();

    write_reg(eop_pkg::REG_DPP, 1);
    write_reg(eop_pkg::REG_TW, 20'hFFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_random(35);
    wait_idle();

    write_reg(eop_pkg::REG_DPP, 0);
    write_reg(eop_pkg::REG_TW, 0);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(25);
    wait_idle();

    write_reg(eop_pkg::REG_DPP, $urandom_range(24'hFFFFFF, 1));
    write_reg(eop_pkg::REG_TW, $urandom_range(20'hFFFFF, 1));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) issue(eop_pkg::REQ_TICK, 0, 0);
    run_random(35);
    wait_idle();

    write_reg(eop_pkg::REG_DPP, $urandom_range(24'h07FFFF, 1));
    write_reg(eop_pkg::REG_TW, $urandom_range(20'h03FFFF, 2000));
    send_idle_pct = 20;
    recv_stall_pct = 20;
    run_random(35);
    wait_idle();

    // long runs in one direction
    write_reg(eop_pkg::REG_DPP, 24'hFFFFFF);
    write_reg(eop_pkg::REG_TW, 7864);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 40; i++) issue(eop_pkg::REQ_LEFT, i[0], ~i[0]);
    for (int i = 0; i < 40; i++) issue(eop_pkg::REQ_RIGHT, i[0], ~i[0]);
    issue(eop_pkg::REQ_TICK, 0, 0);
    for (int i = 0; i < 40; i++) issue(eop_pkg::REQ_LEFT, i[0], i[0]);
    issue(eop_pkg::REQ_TICK, 1, 0);
    wait_idle();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
